[hw/rtl/rmd_pkg.sv]
`timescale 1ns / 1ps

package rmd_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W = LINE_AW + 1;

  localparam int CFG_W = 13;
  localparam int NUM_LANES = 4;
  localparam int CH_W = 8;
  localparam int PAIR_W = CH_W + 1;
  localparam int SUM_W = CH_W + 2;
  localparam int LINE_W = NUM_LANES * PAIR_W;
  localparam int PIX_W = NUM_LANES * CH_W;

  localparam logic [0:0] REG_IN_WIDTH = 1'b0;
  localparam logic [0:0] REG_IN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_IN_WIDTH = CFG_W'(4096);
  localparam logic [CFG_W-1:0] RESET_IN_HEIGHT = CFG_W'(2048);

  typedef struct packed {
    logic dbl;
    logic ld_s1;
    logic use_line;
    logic ld_out;
  } lane_ctrl_t;

endpackage

[hw/rtl/rmd_ram.sv]
`timescale 1ns / 1ps

module rmd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/rmd_lane.sv]
`timescale 1ns / 1ps

module rmd_lane (
  input  logic                       clk,
  input  rmd_pkg::lane_ctrl_t        ctrl,
  input  logic [rmd_pkg::CH_W-1:0]   held,
  input  logic [rmd_pkg::CH_W-1:0]   px,
  input  logic [rmd_pkg::PAIR_W-1:0] line_pair,
  output logic [rmd_pkg::PAIR_W-1:0] pair,
  output logic [rmd_pkg::CH_W-1:0]   avg
);
  import rmd_pkg::*;

  logic [PAIR_W-1:0] s1_pair;
  logic [SUM_W-1:0]  sum;

  always_comb begin
    if (ctrl.dbl) begin
      pair = {px, 1'b0};
    end else begin
      pair = {1'b0, held} + {1'b0, px};
    end
    sum = {1'b0, (ctrl.use_line ? line_pair : s1_pair)} + {1'b0, s1_pair} + SUM_W'(2);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_s1) begin
      s1_pair <= pair;
    end
    if (ctrl.ld_out) begin
      avg <= sum[SUM_W-1:2];
    end
  end

endmodule

[hw/rtl/rgba_mip_downsample_2x2_top.sv]
`timescale 1ns / 1ps

// One mipmap level of an RGBA8 image by a 2x2 box filter with round-half-up
// averaging. Pixels enter in raster order, one per cycle at full rate while
// the output is not stalled; each completed 2x2 block passes through the
// line-store read and then the output register, and tlast marks the final
// output pixel of the image. Four channel lanes work side by side; the pair
// sums of even rows wait in a single-port-write, registered-read line store
// of MAX_WIDTH/2 entries. Any configuration write restarts the frame.
module rgba_mip_downsample_2x2_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [0:0]                 cfg_index,
  input  logic [rmd_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // in_red, in_green, in_blue, in_alpha
  input  logic [rmd_pkg::PIX_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [rmd_pkg::PIX_W-1:0]  m_tdata,
  output logic                       m_tlast
);
  import rmd_pkg::*;

  logic [CFG_W-1:0] in_width;
  logic [CFG_W-1:0] in_height;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [CFG_W-1:0] row;
  logic [CFG_W-1:0] row_next;
  logic [PIX_W-1:0] held_pixel;

  logic [CFG_W-1:0] w_act;
  logic [CFG_W-1:0] h_act;
  logic [CFG_W-1:0] ow;
  logic [CFG_W-1:0] oh;
  logic             w1;
  logic             h1;
  logic             in_range;
  logic             row_in;
  logic             have_pair;
  logic             hold;
  logic             emit;
  logic             line_wr;
  logic             last;
  logic [LINE_AW-1:0] oc;

  logic s_acc;
  logic ld_s1;
  logic adv_out;
  logic s1_valid;
  logic s1_use_line;
  logic s1_last;

  lane_ctrl_t       ctrl;
  logic [LINE_W-1:0] pair_bus;
  logic [LINE_W-1:0] line_rd;

  always_comb begin
    w_act = in_width;
    if (in_width == '0) begin
      w_act = CFG_W'(1);
    end else if (32'(in_width) > MAX_WIDTH) begin
      w_act = CFG_W'(MAX_WIDTH);
    end
    h_act = (in_height == '0) ? CFG_W'(1) : in_height;
    w1 = (w_act == CFG_W'(1));
    h1 = (h_act == CFG_W'(1));
    ow = w1 ? CFG_W'(1) : (w_act >> 1);
    oh = h1 ? CFG_W'(1) : (h_act >> 1);

    in_range = !w1 && (32'(col) < 32'({w_act[CFG_W-1:1], 1'b0}));
    row_in = 32'(row) < 32'({h_act[CFG_W-1:1], 1'b0});
    have_pair = w1 || (in_range && col[0]);
    hold = in_range && !col[0];
    emit = have_pair && (h1 || (row_in && row[0]));
    line_wr = s_acc && have_pair && !h1 && row_in && !row[0];
    oc = w1 ? '0 : col[COL_W-1:1];
    last = (32'(oc) + 1 == 32'(ow)) && (32'(row[CFG_W-1:1]) + 1 == 32'(oh));

    col_next = col + 1'b1;
    row_next = row;
    if (32'(col) + 1 >= 32'(w_act)) begin
      col_next = '0;
      row_next = row + 1'b1;
      if (32'(row) + 1 >= 32'(h_act)) begin
        row_next = '0;
      end
    end

    s_acc = s_tvalid && s_tready;
    adv_out = s1_valid && (!m_tvalid || m_tready);
    s_tready = !s1_valid || adv_out;
    ld_s1 = s_acc && emit;

    ctrl.dbl = w1;
    ctrl.ld_s1 = ld_s1;
    ctrl.use_line = s1_use_line;
    ctrl.ld_out = adv_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width <= RESET_IN_WIDTH;
      in_height <= RESET_IN_HEIGHT;
      col <= '0;
      row <= '0;
      held_pixel <= '0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_IN_WIDTH:  in_width <= cfg_data;
          REG_IN_HEIGHT: in_height <= cfg_data;
          default:       in_width <= in_width;
        endcase
        col <= '0;
        row <= '0;
        held_pixel <= '0;
      end else if (s_acc) begin
        col <= col_next;
        row <= row_next;
        if (hold) begin
          held_pixel <= s_tdata;
        end
      end
      if (ld_s1) begin
        s1_valid <= 1'b1;
      end else if (adv_out) begin
        s1_valid <= 1'b0;
      end
      if (adv_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_s1) begin
      s1_use_line <= !h1;
      s1_last <= last;
    end
    if (adv_out) begin
      m_tlast <= s1_last;
    end
  end

  rmd_ram #(
    .WIDTH(LINE_W),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk    (clk),
    .wr_en  (line_wr),
    .wr_addr(oc),
    .wr_data(pair_bus),
    .rd_en  (ld_s1),
    .rd_addr(oc),
    .rd_data(line_rd)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rmd_lane u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .held     (held_pixel[i*CH_W +: CH_W]),
      .px       (s_tdata[i*CH_W +: CH_W]),
      .line_pair(line_rd[i*PAIR_W +: PAIR_W]),
      .pair     (pair_bus[i*PAIR_W +: PAIR_W]),
      .avg      (m_tdata[i*CH_W +: CH_W])
    );
  end

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(line_wr && ld_s1))
    else $error("line store written and read in one cycle");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are full");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |=> s1_valid)
    else $error("pending block lost during output stall");

  a_s1_feeds_out: assert property (@(posedge clk) disable iff (rst)
    adv_out |=> m_tvalid)
    else $error("advanced block not presented");

endmodule
